/* rtl/ffha_pkg.sv */
// Shared types and constants of the first-fit heap allocator.
// No dependencies; imported by every other file of the block but ffha_ram.
package ffha_pkg;

  localparam int HEAP_BYTES_DEF = 131072;
  localparam int HDR_BYTES      = 12;
  localparam int REQ_W          = 18;
  localparam int ASZ_W          = REQ_W + 1;
  localparam int ADDR_W         = 32;

  typedef enum logic [1:0] {
    K_ALLOC = 2'd0,
    K_OVER  = 2'd1,
    K_FREE  = 2'd2,
    K_NULL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OUT_ALLOC  = 2'd0,
    OUT_NOFIT  = 2'd1,
    OUT_FREED  = 2'd2,
    OUT_IGNORE = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_CHK,
    ST_A_WR,
    ST_F_CHK,
    ST_F_NX,
    ST_F_WB,
    ST_F_WP
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [ASZ_W-1:0]  asize;
    logic [ADDR_W-1:0] blk;
  } req_t;

endpackage

/* rtl/first_fit_heap_allocator_unit.sv */
// Top level of the first-fit heap allocator: front queue plus chain-walking back end.
// Depends on ffha_pkg, ffha_front, ffha_back (and ffha_ram below it).
//
// Usage:
//   in_*  : one request item per handshake; tuser[0] = command (0 alloc, 1 free),
//           tdata = request_bytes [17:0], block_address [49:18].
//   out_* : one result item per request; tdata = granted_address,
//           tuser = outcome (0 allocated, 1 no fit, 2 freed, 3 ignored).
//   cfg_* : cfg_we writes heap_base from cfg_wdata; write only while idle.
// Timing: oversized allocations and null frees finish in the cycle after leaving the
//   queue. An allocate walks headers in ST_A_CHK, plus ST_A_WR when the block is split;
//   a free walks them in ST_F_CHK, then ST_F_NX if there is a successor, ST_F_WB, and
//   ST_F_WP if the predecessor is free. The header RAM's single read port gives one
//   header per cycle along the chain. Requests are carried out one at a time.
// Reset: the first cycle after reset writes the single whole-heap free header;
//   requests may queue meanwhile. heap_base resets to 0.
// Stall: a result waits in the output register while out_tready is low; the
//   2-entry input queue keeps accepting until full.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // request_bytes [17:0], block_address [49:18], zeros
  input  logic [0:0]  in_tuser,   // command [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // granted_address [31:0]
  output logic [1:0]  out_tuser,  // outcome [1:0]
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [ADDR_W-1:0] heap_base_r;
  logic              q_valid, q_pop;
  req_t              q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
    end else if (cfg_we) begin
      heap_base_r <= cfg_wdata;
    end
  end

  ffha_front #(.HEAP_BYTES(HEAP_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tuser[0]),
    .req_bytes (in_tdata[17:0]),
    .blk_addr  (in_tdata[49:18]),
    .heap_base (heap_base_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  ffha_back #(.HEAP_BYTES(HEAP_BYTES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .heap_base (heap_base_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_addr  (out_tdata),
    .out_code  (out_tuser)
  );

  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != OUT_ALLOC) |-> out_tdata == '0)
    else $error("nonzero address on a non-allocate result");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_pop_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && !out_tvalid)
    else $error("request popped while a result is pending");

endmodule

/* rtl/ffha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ffha_front.sv */
// Front end: accepts requests, classifies them and holds them in a 2-deep queue.
// Depends on ffha_pkg.
module ffha_front import ffha_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [REQ_W-1:0]  req_bytes,
  input  logic [ADDR_W-1:0] blk_addr,
  input  logic [ADDR_W-1:0] heap_base,
  output logic              q_valid,
  output req_t              q_data,
  input  logic              q_pop
);

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t       cls;
  logic       push;

  always_comb begin
    cls.asize = (ASZ_W'(req_bytes) + ASZ_W'(3)) & ~ASZ_W'(3);
    cls.blk   = blk_addr - heap_base - ADDR_W'(HDR_BYTES);
    if (cmd) begin
      cls.kind = (blk_addr == '0) ? K_NULL : K_FREE;
    end else begin
      cls.kind = (ADDR_W'(req_bytes) > ADDR_W'(HEAP_BYTES)) ? K_OVER : K_ALLOC;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

/* rtl/ffha_back.sv */
// Back end: walks the header chain, splits and merges blocks, and holds the result.
// Depends on ffha_pkg and ffha_ram.
module ffha_back import ffha_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] heap_base,
  input  logic              q_valid,
  input  req_t              q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_addr,
  output logic [1:0]        out_code
);

  localparam int WORDS  = HEAP_BYTES / 4;
  localparam int IDX_W  = $clog2(WORDS);
  localparam int SIZE_W = $clog2(HEAP_BYTES);

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              free;
    logic [IDX_W-1:0]  nxt;
    logic              hn;
  } hdr_t;

  state_t            st_r, st_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt, prev_r, prev_nxt;
  hdr_t              prev_hdr_r, prev_hdr_nxt, hb_r, hb_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [ASZ_W-1:0]  asize_r, asize_nxt;
  logic [ADDR_W-1:0] blk_r, blk_nxt;
  logic              ov_r, ov_nxt;
  logic [ADDR_W-1:0] oa_r, oa_nxt;
  logic [1:0]        oc_r, oc_nxt;

  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  hdr_t              wdata, rd;
  logic [ADDR_W-1:0] cur_byte;
  logic              fits, split;
  logic [IDX_W-1:0]  split_idx;

  ffha_ram #(.WIDTH($bits(hdr_t)), .DEPTH(WORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd)
  );

  assign cur_byte  = {{(ADDR_W-IDX_W-2){1'b0}}, cur_r, 2'b00};
  assign fits      = rd.free && (ADDR_W'(rd.size) >= ADDR_W'(asize_r));
  assign split     = (ADDR_W'(rd.size) >= ADDR_W'(asize_r) + ADDR_W'(HDR_BYTES + 4));
  assign split_idx = cur_r + IDX_W'(3) + IDX_W'(asize_r[ASZ_W-1:2]);

  assign out_valid = ov_r;
  assign out_addr  = oa_r;
  assign out_code  = oc_r;

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    prev_hdr_r <= prev_hdr_nxt;
    hb_r       <= hb_nxt;
    asize_r    <= asize_nxt;
    blk_r      <= blk_nxt;
    oa_r       <= oa_nxt;
    oc_r       <= oc_nxt;
    if (!rst_n) begin
      st_r        <= ST_INIT;
      have_prev_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      have_prev_r <= have_prev_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_hdr_nxt  = prev_hdr_r;
    have_prev_nxt = have_prev_r;
    hb_nxt        = hb_r;
    asize_nxt     = asize_r;
    blk_nxt       = blk_r;
    ov_nxt        = ov_r && !out_ready;
    oa_nxt        = oa_r;
    oc_nxt        = oc_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = cur_r;
    wdata         = hb_r;
    re            = 1'b0;
    raddr         = '0;
    case (st_r)
      ST_INIT: begin
        // one free block spanning the whole heap
        we     = 1'b1;
        waddr  = '0;
        wdata  = '{size: SIZE_W'(HEAP_BYTES - HDR_BYTES), free: 1'b1, nxt: '0, hn: 1'b0};
        st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid && !ov_r) begin
          q_pop         = 1'b1;
          cur_nxt       = '0;
          have_prev_nxt = 1'b0;
          asize_nxt     = q_data.asize;
          blk_nxt       = q_data.blk;
          oa_nxt        = '0;
          case (q_data.kind)
            K_ALLOC: begin
              re     = 1'b1;
              st_nxt = ST_A_CHK;
            end
            K_FREE: begin
              re     = 1'b1;
              st_nxt = ST_F_CHK;
            end
            K_OVER: begin
              ov_nxt = 1'b1;
              oc_nxt = OUT_NOFIT;
            end
            default: begin
              ov_nxt = 1'b1;
              oc_nxt = OUT_IGNORE;
            end
          endcase
        end
      end
      ST_A_CHK: begin
        if (fits) begin
          if (split) begin
            we     = 1'b1;
            waddr  = split_idx;
            wdata  = '{size: rd.size - SIZE_W'(asize_r) - SIZE_W'(HDR_BYTES),
                       free: 1'b1, nxt: rd.nxt, hn: rd.hn};
            hb_nxt = '{size: SIZE_W'(asize_r), free: 1'b0, nxt: split_idx, hn: 1'b1};
            st_nxt = ST_A_WR;
          end else begin
            we      = 1'b1;
            wdata   = rd;
            wdata.free = 1'b0;
            ov_nxt  = 1'b1;
            oa_nxt  = heap_base + cur_byte + ADDR_W'(HDR_BYTES);
            oc_nxt  = OUT_ALLOC;
            st_nxt  = ST_IDLE;
          end
        end else if (rd.hn) begin
          re      = 1'b1;
          raddr   = rd.nxt;
          cur_nxt = rd.nxt;
        end else begin
          ov_nxt = 1'b1;
          oc_nxt = OUT_NOFIT;
          st_nxt = ST_IDLE;
        end
      end
      ST_A_WR: begin
        we     = 1'b1;
        ov_nxt = 1'b1;
        oa_nxt = heap_base + cur_byte + ADDR_W'(HDR_BYTES);
        oc_nxt = OUT_ALLOC;
        st_nxt = ST_IDLE;
      end
      ST_F_CHK: begin
        if (cur_byte == blk_r) begin
          hb_nxt      = rd;
          hb_nxt.free = 1'b1;
          if (rd.hn) begin
            re     = 1'b1;
            raddr  = rd.nxt;
            st_nxt = ST_F_NX;
          end else begin
            st_nxt = ST_F_WB;
          end
        end else begin
          prev_nxt      = cur_r;
          prev_hdr_nxt  = rd;
          have_prev_nxt = 1'b1;
          if (rd.hn) begin
            re      = 1'b1;
            raddr   = rd.nxt;
            cur_nxt = rd.nxt;
          end else begin
            ov_nxt = 1'b1;
            oc_nxt = OUT_IGNORE;
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_F_NX: begin
        // absorb a free successor
        if (rd.free) begin
          hb_nxt.size = hb_r.size + SIZE_W'(HDR_BYTES) + rd.size;
          hb_nxt.nxt  = rd.nxt;
          hb_nxt.hn   = rd.hn;
        end
        st_nxt = ST_F_WB;
      end
      ST_F_WB: begin
        we = 1'b1;
        if (have_prev_r && prev_hdr_r.free) begin
          st_nxt = ST_F_WP;
        end else begin
          ov_nxt = 1'b1;
          oc_nxt = OUT_FREED;
          st_nxt = ST_IDLE;
        end
      end
      ST_F_WP: begin
        we     = 1'b1;
        waddr  = prev_r;
        wdata  = '{size: prev_hdr_r.size + SIZE_W'(HDR_BYTES) + hb_r.size,
                   free: 1'b1, nxt: hb_r.nxt, hn: hb_r.hn};
        ov_nxt = 1'b1;
        oc_nxt = OUT_FREED;
        st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
